@@ sv/uuencode_line_decoder_defines.svh @@
// Assertion macros for the uuencode line decoder.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef UUENCODE_LINE_DECODER_DEFINES_SVH
`define UUENCODE_LINE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define UULD_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("uuld check failed");
`define UULD_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) pre |=> post) \
      else $error("uuld check failed");
`else
`define UULD_ASSERT(name, prop)
`define UULD_ASSERT_NEXT(name, pre, post)
`endif
`endif

@@ sv/uuld_pkg.sv @@
// Shared types and constants of the uuencode line decoder.
// No dependencies.
package uuld_pkg;

   localparam logic [7:0] CHAR_LO     = 8'd32;   // space
   localparam logic [7:0] CHAR_HI     = 8'd96;   // backquote
   localparam int         BANK_AW     = 6;
   localparam int         STORE_AW    = BANK_AW + 1;
   localparam int         STORE_DEPTH = 2 ** STORE_AW;
   localparam logic [1:0] GROUP_LAST  = 2'd3;
   localparam logic [6:0] GROUP_BYTES = 7'd3;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_READ,
      B_BYTE,
      B_STATUS
   } back_state_type;

   typedef struct packed {
      logic       bank;
      logic [6:0] count;
      status_type status;
   } desc_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } ram_wr_type;

endpackage

@@ sv/uuld_if.sv @@
// Handshake channels of the uuencode line decoder: character words in,
// result words out. No dependencies.
interface uuld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_line;
   modport source (output valid, ch, end_of_line, input ready);
   modport sink   (input valid, ch, end_of_line, output ready);
endinterface

interface uuld_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;
   logic [1:0] status;
   logic       last;
   modport source (output valid, kind, data_byte, status, last, input ready);
   modport sink   (input valid, kind, data_byte, status, last, output ready);
endinterface

@@ sv/uuencode_line_decoder.sv @@
// uuencode line decoder, top level: front end, descriptor queue, back end
// and a two-bank byte store. Characters: one word per cycle while fewer
// than two decoded lines wait in the queue (one store bank per line).
// Results: each byte is read through the store's single registered read
// port (B_READ, then B_BYTE), so bytes are not sent back to back; the
// status is sent in the cycle after the last byte is taken.
// Synchronous reset clears control state only; the store needs no clearing.
`include "uuencode_line_decoder_defines.svh"

module uuencode_line_decoder import uuld_pkg::*; #(
   parameter int LINE_BYTES_MAX = 63
) (
   input logic         clock,
   input logic         reset,
   uuld_req_if.sink    req_chan,
   uuld_rsp_if.source  rsp_chan
);

   logic                q_full, q_empty, q_push, q_pop;
   desc_type            q_desc, q_head;
   ram_wr_type          ram_wr;
   logic                ram_re;
   logic [STORE_AW-1:0] ram_raddr;
   logic [7:0]          ram_rdata;

   uuld_front #(.LINE_BYTES_MAX(LINE_BYTES_MAX)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_desc (q_desc),
      .ram_wr (ram_wr)
   );

   uuld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_desc),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   uuld_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (ram_wr.en),
      .waddr (ram_wr.addr),
      .wdata (ram_wr.data),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   uuld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp       (rsp_chan)
   );

   // results only come from a queued line
   `UULD_ASSERT(a_rsp_has_line, rsp_chan.valid |-> !q_empty)
   // front never writes into the bank being drained
   `UULD_ASSERT(a_bank_apart, (ram_wr.en && !q_empty) |-> (ram_wr.addr[STORE_AW-1] != q_head.bank))
   // a delivered status frees a queue slot
   `UULD_ASSERT_NEXT(a_status_frees, (rsp_chan.valid && rsp_chan.ready && rsp_chan.kind == KIND_STATUS), !q_full)

endmodule

@@ sv/uuld_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uuld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/uuld_queue.sv @@
// Two-entry queue of line descriptors between front and back.
// Depends on uuld_pkg.
module uuld_queue import uuld_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output desc_type head
);

   desc_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/uuld_front.sv @@
// Front end: takes characters, decodes groups into the byte store and
// posts a descriptor per line. Depends on uuld_pkg and uuld_if.
module uuld_front import uuld_pkg::*; #(
   parameter int LINE_BYTES_MAX = 63
) (
   input  logic       clock,
   input  logic       reset,
   uuld_req_if.sink   req,
   input  logic       q_full,
   output logic       q_push,
   output desc_type   q_desc,
   output ram_wr_type ram_wr
);

   localparam logic [6:0] BYTES_MAX = 7'(LINE_BYTES_MAX);

   logic       mid_ff, mid_in;
   logic       bank_ff, bank_in;
   logic [5:0] len_ff, len_in;
   logic [6:0] n_ff, n_in;
   logic [1:0] gidx_ff, gidx_in;
   logic [6:0] cnt_ff, cnt_in;
   logic       bad_ff, bad_in;
   logic [5:0] g0_ff, g1_ff, g2_ff;

   logic       accept;
   logic [5:0] v;
   logic [6:0] n_cur, cnt_cur;
   logic [1:0] gidx_cur, k;
   logic       bad_cur, active, bad_char, good;
   logic       en1, en2, byte_en;
   logic [6:0] idx, sum;
   logic [1:0] e;
   logic [7:0] byte_val;
   logic       short;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      v        = 6'(req.ch - CHAR_LO);
      len_in   = mid_ff ? len_ff : v;
      n_cur    = mid_ff ? n_ff : 7'd0;
      cnt_cur  = mid_ff ? cnt_ff : 7'd0;
      gidx_cur = mid_ff ? gidx_ff : 2'd0;
      bad_cur  = mid_ff ? bad_ff : 1'b0;
      active   = mid_ff && (n_cur < {1'b0, len_in});
      bad_char = (req.ch < CHAR_LO) || (req.ch > CHAR_HI);
      good     = active && !bad_cur && !bad_char;
      bad_in   = bad_cur || (active && bad_char);

      en1     = (n_cur + 7'd1) < {1'b0, len_in};
      en2     = (n_cur + 7'd2) < {1'b0, len_in};
      k       = gidx_cur - 2'd1;
      byte_en = (k == 2'd0) || ((k == 2'd1) && en1) || ((k == 2'd2) && en2);
      idx     = cnt_cur + 7'(k);
      case (gidx_cur)
         2'd1:    byte_val = {g0_ff, v[5:4]};
         2'd2:    byte_val = {g1_ff[3:0], v[5:2]};
         default: byte_val = {g2_ff[1:0], v};
      endcase

      e   = 2'd1 + 2'(en1) + 2'(en2);
      sum = cnt_cur + 7'(e);
      cnt_in = cnt_cur;
      if (good && gidx_cur == GROUP_LAST) begin
         cnt_in = (sum > BYTES_MAX) ? BYTES_MAX : sum;
      end
      n_in    = (active && gidx_cur == GROUP_LAST) ? n_cur + GROUP_BYTES : n_cur;
      gidx_in = active ? gidx_cur + 2'd1 : gidx_cur;

      mid_in  = !req.end_of_line;
      bank_in = req.end_of_line ? ~bank_ff : bank_ff;
      short   = (len_in != 6'd0) && (n_in < {1'b0, len_in});
   end

   always_comb begin
      ram_wr.en   = accept && good && (gidx_cur != 2'd0) && byte_en && (idx < BYTES_MAX);
      ram_wr.addr = {bank_ff, idx[BANK_AW-1:0]};
      ram_wr.data = byte_val;

      q_push      = accept && req.end_of_line;
      q_desc.bank = bank_ff;
      if (len_in == 6'd0) begin
         q_desc.count  = 7'd0;
         q_desc.status = ST_OK;
      end else if (short) begin
         q_desc.count  = 7'd0;
         q_desc.status = ST_SHORT;
      end else begin
         q_desc.count  = cnt_in;
         q_desc.status = bad_in ? ST_BAD : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff  <= 1'b0;
         bank_ff <= 1'b0;
      end else if (accept) begin
         mid_ff  <= mid_in;
         bank_ff <= bank_in;
      end
      if (accept) begin
         len_ff  <= len_in;
         n_ff    <= n_in;
         gidx_ff <= gidx_in;
         cnt_ff  <= cnt_in;
         bad_ff  <= bad_in;
         if (good && gidx_cur == 2'd0) begin
            g0_ff <= v;
         end
         if (good && gidx_cur == 2'd1) begin
            g1_ff <= v;
         end
         if (good && gidx_cur == 2'd2) begin
            g2_ff <= v;
         end
      end
   end

endmodule

@@ sv/uuld_back.sv @@
// Back end: drains a line's bytes from the store, then sends its status.
// Depends on uuld_pkg and uuld_if.
module uuld_back import uuld_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  desc_type            q_head,
   output logic                q_pop,
   output logic                ram_re,
   output logic [STORE_AW-1:0] ram_raddr,
   input  logic [7:0]          ram_rdata,
   uuld_rsp_if.source          rsp
);

   back_state_type state_ff, state_in;
   logic [BANK_AW-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         B_IDLE: begin
            idx_in = '0;
            if (!q_empty) begin
               state_in = (q_head.count == 7'd0) ? B_STATUS : B_READ;
            end
         end
         B_READ: begin
            state_in = B_BYTE;
         end
         B_BYTE: begin
            if (rsp.ready) begin
               idx_in = idx_ff + 1'b1;
               if (({1'b0, idx_ff} + 7'd1) == q_head.count) begin
                  state_in = B_STATUS;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_STATUS: begin
            if (rsp.ready) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      ram_re        = (state_ff == B_READ);
      ram_raddr     = {q_head.bank, idx_ff};
      rsp.valid     = (state_ff == B_BYTE) || (state_ff == B_STATUS);
      rsp.kind      = (state_ff == B_STATUS) ? KIND_STATUS : KIND_BYTE;
      rsp.data_byte = (state_ff == B_BYTE) ? ram_rdata : 8'd0;
      rsp.status    = (state_ff == B_STATUS) ? q_head.status : ST_OK;
      rsp.last      = (state_ff == B_STATUS);
      q_pop         = (state_ff == B_STATUS) && rsp.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
   end

endmodule
